>>> hdl/audio_frame_drop_pacer_macros.svh
// Assertion macros shared by the frame drop pacer modules.
`ifndef AUDIO_FRAME_DROP_PACER_MACROS_SVH
`define AUDIO_FRAME_DROP_PACER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AFDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afdp same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define AFDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afdp next-cycle check failed");

`endif

>>> hdl/afdp_pkg.sv
// Package: shared types and constants of the frame drop pacer.
package afdp_pkg;

    localparam int LEVEL_W           = 24;
    localparam int FRAMES_W          = 16;
    localparam int CH_W              = 4;
    // Wide enough for 480 bytes times the largest 4-bit channel count
    localparam int DIVISOR_W         = 13;
    localparam int DIFF_W            = FRAMES_W + 2;
    localparam int FRAME_SAMPLES     = 240;
    localparam int BYTES_PER_CH      = FRAME_SAMPLES * 2;
    localparam int MIN_FRAMES        = 2;
    localparam int MAX_FRAMES        = 4;
    localparam int STOP_LIMIT        = 20;
    localparam int DIV_STEPS         = LEVEL_W;
    localparam int STEP_W            = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ACT_PLAY  = 2'd0,
        ACT_HARD  = 2'd1,
        ACT_PACED = 2'd2
    } action_t;

    typedef enum logic {
        REG_BASELINE = 1'b0,
        REG_CHANNELS = 1'b1
    } reg_index_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

endpackage

>>> hdl/afdp_ctrl.sv
// Controller: sequences load, divide steps and the decision for each frame.
`include "audio_frame_drop_pacer_macros.svh"

module afdp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output afdp_pkg::cmd_t cmd
);
    import afdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `AFDP_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `AFDP_ASSERT_NEXT(a_div_end, clk, rst_n,
        state_reg == ST_DIV && step_reg == STEP_W'(DIV_STEPS - 1), state_reg == ST_DECIDE)
    `AFDP_ASSERT_NEXT(a_load_starts, clk, rst_n, in_valid && in_ready,
        state_reg == ST_DIV && step_reg == '0)

endmodule

>>> hdl/afdp_dp.sv
// Datapath: config registers, serial divider, pending drop state and result register.
`include "audio_frame_drop_pacer_macros.svh"

module afdp_dp #(
    parameter int DROP_SPACING = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [afdp_pkg::LEVEL_W-1:0]   cfg_data,
    input  logic [afdp_pkg::LEVEL_W-1:0]   queued_bytes,
    input  afdp_pkg::cmd_t                 cmd,
    output logic [1:0]                     action,
    output logic [afdp_pkg::FRAMES_W-1:0]  frames_queued
);
    import afdp_pkg::*;

    localparam int IDX_W = $clog2(DROP_SPACING);

    logic [LEVEL_W-1:0]    baseline_reg;
    logic [CH_W-1:0]       channels_reg;
    logic [LEVEL_W-1:0]    dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [FRAMES_W-1:0]   ph_reg, ph_next;
    logic [FRAMES_W-1:0]   ps_reg, ps_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    action_t               action_reg, action_next;
    logic [FRAMES_W-1:0]   frames_reg;

    logic [LEVEL_W:0]      level_diff;
    logic [LEVEL_W-1:0]    bytes_clamped;
    logic [CH_W-1:0]       ch_eff;
    logic [DIVISOR_W:0]    trial;
    logic                  trial_ge;
    logic [FRAMES_W-1:0]   frames;
    logic signed [DIFF_W-1:0] diff_hard, diff_all;
    logic [IDX_W:0]        idx_inc;
    logic [FRAMES_W-1:0]   ph_mid, ps_mid;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            channels_reg <= CH_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BASELINE: baseline_reg <= cfg_data;
                REG_CHANNELS: channels_reg <= cfg_data[CH_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp level minus baseline at zero; a zero channel count acts as one
    assign level_diff    = {1'b0, queued_bytes} - {1'b0, baseline_reg};
    assign bytes_clamped = level_diff[LEVEL_W] ? '0 : level_diff[LEVEL_W-1:0];
    assign ch_eff        = (channels_reg == '0) ? CH_W'(1) : channels_reg;

    // Restoring divider step: one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[LEVEL_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            dvd_next = bytes_clamped;
            rem_next = '0;
        end
        else if (cmd.step)
        begin
            dvd_next = {dvd_reg[LEVEL_W-2:0], trial_ge};
            rem_next = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                                : trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            divisor_reg <= DIVISOR_W'(ch_eff) * DIVISOR_W'(BYTES_PER_CH);
        end
    end

    // Quotient never exceeds the frame width for a 24-bit level
    assign frames    = dvd_reg[FRAMES_W-1:0];
    assign diff_hard = $signed({2'b00, frames}) - $signed({2'b00, ph_reg});
    assign diff_all  = diff_hard - $signed({2'b00, ps_reg});
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;

    // Decide: update pending drops, then take at most one drop
    always_comb
    begin
        idx_next    = (idx_inc == (IDX_W + 1)'(DROP_SPACING)) ? '0 : idx_inc[IDX_W-1:0];
        ph_mid      = ph_reg;
        ps_mid      = ps_reg;
        ph_next     = ph_reg;
        ps_next     = ps_reg;
        action_next = ACT_PLAY;
        if (frames <= FRAMES_W'(MIN_FRAMES))
        begin
            ph_mid = '0;
            ps_mid = '0;
        end
        else if (diff_hard < 0 || diff_hard > DIFF_W'(STOP_LIMIT))
        begin
            ph_mid = frames - FRAMES_W'(MIN_FRAMES);
        end
        else if (diff_all < 0 || diff_all > DIFF_W'(MAX_FRAMES))
        begin
            ps_mid = frames - FRAMES_W'(MIN_FRAMES);
        end
        ph_next = ph_mid;
        ps_next = ps_mid;
        if (ph_mid != '0)
        begin
            ph_next     = ph_mid - 1'b1;
            action_next = ACT_HARD;
        end
        else if (ps_mid != '0 && idx_next == '0)
        begin
            ps_next     = ps_mid - 1'b1;
            action_next = ACT_PACED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= '0;
            ps_reg  <= '0;
            idx_reg <= '0;
        end
        else if (cmd.commit)
        begin
            ph_reg  <= ph_next;
            ps_reg  <= ps_next;
            idx_reg <= idx_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            action_reg <= action_next;
            frames_reg <= frames;
        end
    end

    assign action        = action_reg;
    assign frames_queued = frames_reg;

    `AFDP_ASSERT_NEXT(a_low_level_plays, clk, rst_n,
        cmd.commit && frames <= FRAMES_W'(MIN_FRAMES), action_reg == ACT_PLAY && ph_reg == '0)

endmodule

>>> hdl/audio_frame_drop_pacer.sv
// Top level: frame drop pacer built from controller and datapath.
//
// Usage: one input transfer per audio frame carries queued_bytes, the playback
// queue level. One output transfer per frame carries action (0 play, 1 hard
// drop, 2 paced drop) and frames_queued, the whole frames left after removing
// the baseline. Configuration (baseline_bytes at index 0, channel_count at
// index 1) is written through cfg_we/cfg_index/cfg_data while the block is idle.
// Timing: the restoring divider resolves one of 24 quotient bits per cycle,
// then the decision state commits the result and raises out_valid. A new
// frame is taken only in the idle state, so none is accepted before the last
// is decided; in_ready rises again the cycle after the decision.
// The output register keeps a finished result while the next frame is divided;
// if the receiver stalls, the next decision waits until the output is taken.
// Reset clears pending drops and the call counter, sets baseline to 0 and
// channel_count to 2, and leaves no result pending.
module audio_frame_drop_pacer #(
    parameter int DROP_SPACING = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [afdp_pkg::LEVEL_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [afdp_pkg::LEVEL_W-1:0]   queued_bytes,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     action,
    output logic [afdp_pkg::FRAMES_W-1:0]  frames_queued
);
    import afdp_pkg::*;

    cmd_t cmd;

    // Sequencer
    afdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Divider, drop state and result
    afdp_dp #(
        .DROP_SPACING (DROP_SPACING)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .queued_bytes  (queued_bytes),
        .cmd           (cmd),
        .action        (action),
        .frames_queued (frames_queued)
    );

endmodule
